// ----- hdl/scsw_pkg.sv -----
package scsw_pkg;

   localparam int CHIP_W     = 6;
   localparam int CHIP_EXT_W = 9;
   localparam int POS_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 7;
   localparam int MAX_CHIPS  = 64;
   localparam int OUT_LIMIT  = 64;
   localparam int CMD_DEPTH  = 4;
   localparam int RSP_DEPTH  = 2;

   typedef enum logic [1:0] {
      OP_WRITE_BIT    = 2'd0,
      OP_WRITE_BYTE   = 2'd1,
      OP_BATCH_BEGIN  = 2'd2,
      OP_BATCH_COMMIT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_UPDATE,
      BACK_FLUSH
   } back_state_type;

   typedef struct packed {
      logic              store;
      logic              is_bit;
      logic [CHIP_W-1:0] chip;
      logic [POS_W-1:0]  pos;
      logic              val;
      logic [BYTE_W-1:0] data;
      logic              flush;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [CHIP_W-1:0] out_chip;
      logic              last_byte;
   } rsp_type;

endpackage

// ----- hdl/scsw_queue.sv -----
module scsw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/scsw_front.sv -----
module scsw_front #(
   parameter int MAX_CHIPS = scsw_pkg::MAX_CHIPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [scsw_pkg::CHIP_W-1:0]   req_chip_index,
   input  logic [scsw_pkg::POS_W-1:0]    req_bit_position,
   input  logic                          req_bit_value,
   input  logic [scsw_pkg::BYTE_W-1:0]   req_byte_value,
   output logic                          cmd_push,
   output scsw_pkg::cmd_type             cmd_data,
   input  logic                          cmd_full
);

   logic                                batch_ff, batch_in;
   logic                                accept;
   logic                                in_range;
   logic [scsw_pkg::CHIP_EXT_W-1:0]     chip_ext;
   scsw_pkg::op_type                    op;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign op       = scsw_pkg::op_type'(req_operation);
   assign chip_ext = {{(scsw_pkg::CHIP_EXT_W - scsw_pkg::CHIP_W){1'b0}}, req_chip_index};
   assign in_range = (chip_ext < scsw_pkg::CHIP_EXT_W'(MAX_CHIPS));

   always_comb begin
      batch_in       = batch_ff;
      cmd_push       = 1'b0;
      cmd_data.store = 1'b0;
      cmd_data.is_bit = (op == scsw_pkg::OP_WRITE_BIT);
      cmd_data.chip  = req_chip_index;
      cmd_data.pos   = req_bit_position;
      cmd_data.val   = req_bit_value;
      cmd_data.data  = req_byte_value;
      cmd_data.flush = 1'b0;
      case (op)
         scsw_pkg::OP_WRITE_BIT, scsw_pkg::OP_WRITE_BYTE: begin
            cmd_push       = accept;
            cmd_data.store = in_range;
            cmd_data.flush = !batch_ff;
         end
         scsw_pkg::OP_BATCH_BEGIN: begin
            if (accept) begin
               batch_in = 1'b1;
            end
         end
         scsw_pkg::OP_BATCH_COMMIT: begin
            cmd_push       = accept && batch_ff;
            cmd_data.flush = 1'b1;
            if (accept) begin
               batch_in = 1'b0;
            end
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= 1'b0;
      end else begin
         batch_ff <= batch_in;
      end
   end

endmodule

// ----- hdl/scsw_back.sv -----
module scsw_back #(
   parameter int MAX_CHIPS = scsw_pkg::MAX_CHIPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [scsw_pkg::CHIP_W-1:0]   last_chip,
   input  scsw_pkg::cmd_type             cmd_data,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output logic                          out_push,
   output scsw_pkg::rsp_type             out_data,
   input  logic                          out_full
);

   localparam int AW = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

   logic [scsw_pkg::BYTE_W-1:0]  mem [MAX_CHIPS];
   logic                         valid_ff [MAX_CHIPS];

   scsw_pkg::back_state_type     state_ff, state_in;
   scsw_pkg::cmd_type            cmd_ff, cmd_in;
   logic [scsw_pkg::CHIP_W-1:0]  cnt_ff, cnt_in;
   logic                         pend_ff, pend_in;
   logic [scsw_pkg::CHIP_W-1:0]  pend_chip_ff, pend_chip_in;
   logic                         pend_last_ff, pend_last_in;
   logic [scsw_pkg::BYTE_W-1:0]  rd_data_ff;
   logic                         rd_valid_ff;

   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [scsw_pkg::BYTE_W-1:0]  wr_data;
   logic [scsw_pkg::BYTE_W-1:0]  old_byte;
   logic [scsw_pkg::BYTE_W-1:0]  mask;
   logic                         slot_free;
   logic [scsw_pkg::CHIP_EXT_W-1:0] cmd_chip_ext, upd_chip_ext, cnt_ext;

   assign cmd_chip_ext = {{(scsw_pkg::CHIP_EXT_W - scsw_pkg::CHIP_W){1'b0}}, cmd_data.chip};
   assign upd_chip_ext = {{(scsw_pkg::CHIP_EXT_W - scsw_pkg::CHIP_W){1'b0}}, cmd_ff.chip};
   assign cnt_ext      = {{(scsw_pkg::CHIP_EXT_W - scsw_pkg::CHIP_W){1'b0}}, cnt_ff};

   assign old_byte  = rd_valid_ff ? rd_data_ff : '0;
   assign mask      = scsw_pkg::BYTE_W'(1) << cmd_ff.pos;
   assign out_push  = pend_ff && !out_full;
   assign slot_free = !pend_ff || !out_full;

   assign out_data.out_byte  = old_byte;
   assign out_data.out_chip  = pend_chip_ff;
   assign out_data.last_byte = pend_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scsw_pkg::BACK_IDLE: begin
            if (!cmd_empty && !pend_ff) begin
               state_in = scsw_pkg::BACK_UPDATE;
            end
         end
         scsw_pkg::BACK_UPDATE: begin
            state_in = cmd_ff.flush ? scsw_pkg::BACK_FLUSH : scsw_pkg::BACK_IDLE;
         end
         scsw_pkg::BACK_FLUSH: begin
            if (slot_free && (cnt_ff == '0)) begin
               state_in = scsw_pkg::BACK_IDLE;
            end
         end
         default: begin
            state_in = scsw_pkg::BACK_IDLE;
         end
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = cmd_chip_ext[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = upd_chip_ext[AW-1:0];
      wr_data      = cmd_ff.data;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      pend_in      = out_push ? 1'b0 : pend_ff;
      pend_chip_in = pend_chip_ff;
      pend_last_in = pend_last_ff;
      case (state_ff)
         scsw_pkg::BACK_IDLE: begin
            cmd_pop = !cmd_empty && !pend_ff;
            rd_en   = cmd_pop;
            if (cmd_pop) begin
               cmd_in = cmd_data;
            end
         end
         scsw_pkg::BACK_UPDATE: begin
            wr_en  = cmd_ff.store;
            cnt_in = last_chip;
            if (cmd_ff.is_bit) begin
               wr_data = cmd_ff.val ? (old_byte | mask) : (old_byte & ~mask);
            end
         end
         scsw_pkg::BACK_FLUSH: begin
            rd_en   = slot_free;
            rd_addr = cnt_ext[AW-1:0];
            if (slot_free) begin
               pend_in      = 1'b1;
               pend_chip_in = cnt_ff;
               pend_last_in = (cnt_ff == '0);
               cnt_in       = cnt_ff - scsw_pkg::CHIP_W'(1);
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scsw_pkg::BACK_IDLE;
         pend_ff  <= 1'b0;
         for (int i = 0; i < MAX_CHIPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      pend_chip_ff <= pend_chip_in;
      pend_last_ff <= pend_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule

// ----- hdl/shift_chain_shadow_writer.sv -----
// Flow: a write outside a batch, or a commit of an open batch, passes the command queue and
// the back end's IDLE, UPDATE and FLUSH states before its first byte reaches the rsp ports;
// bytes then follow one per cycle while the response queue has room. The back end takes a
// new command only in IDLE with no byte pending; the front takes one transaction per
// cycle while the four-entry command queue has room. Reset: synchronous; clears queues,
// batch flag and shadow valid bits (shadow reads as zero); chain length set to 1.
module shift_chain_shadow_writer #(
   parameter int MAX_CHIPS = scsw_pkg::MAX_CHIPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_operation,
   input  logic [scsw_pkg::CHIP_W-1:0]   req_chip_index,
   input  logic [scsw_pkg::POS_W-1:0]    req_bit_position,
   input  logic                          req_bit_value,
   input  logic [scsw_pkg::BYTE_W-1:0]   req_byte_value,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [scsw_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic [scsw_pkg::CHIP_W-1:0]   rsp_out_chip,
   output logic                          rsp_last_byte,
   input  logic                          csr_wr_en,
   input  logic [scsw_pkg::LEN_W-1:0]    csr_chain_length
);

   localparam int CAP = (MAX_CHIPS < scsw_pkg::OUT_LIMIT) ? MAX_CHIPS : scsw_pkg::OUT_LIMIT;

   logic [scsw_pkg::LEN_W-1:0]   chain_len_ff, chain_len_in;
   logic [scsw_pkg::LEN_W-1:0]   chips_used;
   logic [scsw_pkg::LEN_W-1:0]   last_idx;
   logic [scsw_pkg::CHIP_W-1:0]  last_chip;

   scsw_pkg::cmd_type            front_cmd, queued_cmd;
   logic                         front_push, cmd_full, cmd_empty, cmd_pop;
   scsw_pkg::rsp_type            back_rsp, rsp_head;
   logic                         back_push, rsp_full;

   assign chain_len_in = csr_wr_en ? csr_chain_length : chain_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_len_ff <= scsw_pkg::LEN_W'(1);
      end else begin
         chain_len_ff <= chain_len_in;
      end
   end

   always_comb begin
      chips_used = chain_len_ff;
      if (chain_len_ff == '0) begin
         chips_used = scsw_pkg::LEN_W'(1);
      end else if (chain_len_ff > scsw_pkg::LEN_W'(CAP)) begin
         chips_used = scsw_pkg::LEN_W'(CAP);
      end
   end

   assign last_idx  = chips_used - scsw_pkg::LEN_W'(1);
   assign last_chip = last_idx[scsw_pkg::CHIP_W-1:0];

   scsw_front #(
      .MAX_CHIPS (MAX_CHIPS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_chip_index   (req_chip_index),
      .req_bit_position (req_bit_position),
      .req_bit_value    (req_bit_value),
      .req_byte_value   (req_byte_value),
      .cmd_push         (front_push),
      .cmd_data         (front_cmd),
      .cmd_full         (cmd_full)
   );

   scsw_queue #(
      .WIDTH ($bits(scsw_pkg::cmd_type)),
      .DEPTH (scsw_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (queued_cmd),
      .empty     (cmd_empty)
   );

   scsw_back #(
      .MAX_CHIPS (MAX_CHIPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .last_chip (last_chip),
      .cmd_data  (queued_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .out_push  (back_push),
      .out_data  (back_rsp),
      .out_full  (rsp_full)
   );

   scsw_queue #(
      .WIDTH ($bits(scsw_pkg::rsp_type)),
      .DEPTH (scsw_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_out_byte  = rsp_head.out_byte;
   assign rsp_out_chip  = rsp_head.out_chip;
   assign rsp_last_byte = rsp_head.last_byte;

endmodule

// ----- tb/sv/shift_chain_shadow_writer_tb.sv -----
`timescale 1ns / 1ps

module shift_chain_shadow_writer_tb;
   import scsw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 40;

   class chain_flush_checker;
      bit [7:0] shadow [MAX_CHIPS];
      bit       batch_open;
      int       chips_in_use;
      rsp_type  bytes_due [$];
      int       errors;

      function new();
         foreach (shadow[i]) shadow[i] = '0;
         batch_open   = 1'b0;
         chips_in_use = 1;
         errors       = 0;
      endfunction

      function void set_chain_length(bit [LEN_W-1:0] len);
         if (len == 0)
            chips_in_use = 1;
         else if (len > OUT_LIMIT)
            chips_in_use = OUT_LIMIT;
         else
            chips_in_use = int'(len);
      endfunction

      function void queue_flush();
         rsp_type due;
         for (int c = chips_in_use - 1; c >= 0; c--) begin
            due.out_byte  = shadow[c];
            due.out_chip  = c[CHIP_W-1:0];
            due.last_byte = (c == 0);
            bytes_due.push_back(due);
         end
      endfunction

      function void note_request(op_type op, bit [CHIP_W-1:0] chip, bit [POS_W-1:0] pos,
                                 bit val, bit [BYTE_W-1:0] data);
         case (op)
            OP_WRITE_BIT, OP_WRITE_BYTE: begin
               if (op == OP_WRITE_BYTE)
                  shadow[chip] = data;
               else
                  shadow[chip][pos] = val;
               if (!batch_open)
                  queue_flush();
            end
            OP_BATCH_BEGIN: begin
               batch_open = 1'b1;
            end
            OP_BATCH_COMMIT: begin
               if (batch_open) begin
                  batch_open = 1'b0;
                  queue_flush();
               end
            end
         endcase
      endfunction

      function void check_result(bit [BYTE_W-1:0] out_byte, bit [CHIP_W-1:0] out_chip,
                                 bit last_byte);
         rsp_type due;
         if (bytes_due.size() == 0) begin
            $display("%0t: unexpected result: byte %h chip %0d last %0b",
                     $time, out_byte, out_chip, last_byte);
            errors++;
            return;
         end
         due = bytes_due.pop_front();
         if (due.out_byte != out_byte) begin
            $display("%0t: out_byte mismatch: expected %h actual %h", $time, due.out_byte,
                     out_byte);
            errors++;
         end
         if (due.out_chip != out_chip) begin
            $display("%0t: out_chip mismatch: expected %0d actual %0d", $time, due.out_chip,
                     out_chip);
            errors++;
         end
         if (due.last_byte != last_byte) begin
            $display("%0t: last_byte mismatch: expected %0b actual %0b", $time,
                     due.last_byte, last_byte);
            errors++;
         end
      endfunction

      function int pending();
         return bytes_due.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [1:0]          req_operation;
   logic [CHIP_W-1:0]   req_chip_index;
   logic [POS_W-1:0]    req_bit_position;
   logic                req_bit_value;
   logic [BYTE_W-1:0]   req_byte_value;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic [CHIP_W-1:0]   rsp_out_chip;
   logic                rsp_last_byte;
   logic                csr_wr_en;
   logic [LEN_W-1:0]    csr_chain_length;

   chain_flush_checker flush_check = new();
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int cur_len = 1;
   int cycle_count = 0;

   shift_chain_shadow_writer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_chip_index   (req_chip_index),
      .req_bit_position (req_bit_position),
      .req_bit_value    (req_bit_value),
      .req_byte_value   (req_byte_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_chip     (rsp_out_chip),
      .rsp_last_byte    (rsp_last_byte),
      .csr_wr_en        (csr_wr_en),
      .csr_chain_length (csr_chain_length)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            flush_check.set_chain_length(csr_chain_length);
         if (req_push && !req_full)
            flush_check.note_request(op_type'(req_operation), req_chip_index,
                                     req_bit_position, req_bit_value, req_byte_value);
         if (rsp_pop && !rsp_empty)
            flush_check.check_result(rsp_out_byte, rsp_out_chip, rsp_last_byte);
      end
   end

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // entered and left just after a falling edge
   task automatic send_request(op_type op, logic [CHIP_W-1:0] chip, logic [POS_W-1:0] pos,
                               logic val, logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push         <= 1'b1;
      req_operation    <= op;
      req_chip_index   <= chip;
      req_bit_position <= pos;
      req_bit_value    <= val;
      req_byte_value   <= data;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (flush_check.pending() != 0);
   endtask

   task automatic write_chain_length(logic [LEN_W-1:0] len);
      csr_chain_length <= len;
      csr_wr_en        <= 1'b1;
      @(negedge clock);
      csr_wr_en        <= 1'b0;
      cur_len = (len == 0) ? 1 : (len > OUT_LIMIT) ? OUT_LIMIT : int'(len);
   endtask

   task automatic send_random_write();
      op_type op;
      int     chip;
      op   = $urandom_range(1) ? OP_WRITE_BYTE : OP_WRITE_BIT;
      chip = $urandom_range(1) ? $urandom_range(cur_len - 1) : $urandom_range(63);
      send_request(op, CHIP_W'(chip), POS_W'($urandom_range(7)), 1'($urandom_range(1)),
                   BYTE_W'($urandom_range(255)));
   endtask

   task automatic send_random_marker(op_type op);
      send_request(op, CHIP_W'($urandom_range(63)), POS_W'($urandom_range(7)),
                   1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
   endtask

   task automatic random_traffic(int count);
      int sent;
      int pick;
      int writes;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(24) == 0)
            drain_results();
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_random_write();
            sent++;
         end else if (pick < 85) begin
            writes = $urandom_range(4, 1);
            send_random_marker(OP_BATCH_BEGIN);
            repeat (writes) send_random_write();
            send_random_marker(OP_BATCH_COMMIT);
            sent += writes + 2;
         end else begin
            send_random_marker(op_type'($urandom_range(3)));
            sent++;
         end
      end
   endtask

   task automatic run_phase(logic [LEN_W-1:0] len, int mode, int count);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_chain_length(len);
      case (mode)
         0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
         1: begin send_idle_pct = 69; pop_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  pop_stall_pct = 69; end
         default: begin send_idle_pct = 10; pop_stall_pct = 10; end
      endcase
      random_traffic(count);
   endtask

   initial begin
      reset            = 1'b1;
      req_push         = 1'b0;
      req_operation    = OP_WRITE_BIT;
      req_chip_index   = '0;
      req_bit_position = '0;
      req_bit_value    = 1'b0;
      req_byte_value   = '0;
      rsp_pop          = 1'b0;
      csr_wr_en        = 1'b0;
      csr_chain_length = 7'd1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: chain of four, chips beyond it, batch corner cases
      write_chain_length(7'd4);
      send_request(OP_WRITE_BYTE,   6'd0,  3'd0, 1'b0, 8'hFF);
      send_request(OP_WRITE_BYTE,   6'd3,  3'd7, 1'b1, 8'h81);
      send_request(OP_WRITE_BYTE,   6'd63, 3'd0, 1'b0, 8'hAA);
      send_request(OP_WRITE_BIT,    6'd1,  3'd7, 1'b1, 8'h00);
      send_request(OP_WRITE_BIT,    6'd1,  3'd0, 1'b1, 8'hFF);
      send_request(OP_WRITE_BIT,    6'd0,  3'd7, 1'b0, 8'hFF);
      send_request(OP_WRITE_BIT,    6'd0,  3'd0, 1'b0, 8'h00);
      send_request(OP_BATCH_COMMIT, 6'd63, 3'd7, 1'b1, 8'hFF);
      send_request(OP_BATCH_BEGIN,  6'd0,  3'd0, 1'b0, 8'h00);
      send_request(OP_BATCH_BEGIN,  6'd63, 3'd7, 1'b1, 8'hFF);
      send_request(OP_WRITE_BYTE,   6'd2,  3'd0, 1'b0, 8'h5A);
      send_request(OP_WRITE_BIT,    6'd3,  3'd3, 1'b0, 8'hFF);
      send_request(OP_WRITE_BIT,    6'd40, 3'd2, 1'b1, 8'h00);
      send_request(OP_BATCH_COMMIT, 6'd0,  3'd0, 1'b0, 8'h00);
      send_request(OP_BATCH_COMMIT, 6'd0,  3'd0, 1'b0, 8'h00);
      send_request(OP_WRITE_BYTE,   6'd62, 3'd7, 1'b1, 8'h55);
      send_request(OP_BATCH_BEGIN,  6'd21, 3'd5, 1'b1, 8'hC3);
      send_request(OP_WRITE_BYTE,   6'd1,  3'd0, 1'b0, 8'h00);
      send_request(OP_WRITE_BIT,    6'd2,  3'd6, 1'b1, 8'h00);
      send_request(OP_BATCH_COMMIT, 6'd42, 3'd2, 1'b0, 8'h3C);
      send_request(OP_WRITE_BIT,    6'd3,  3'd4, 1'b1, 8'h00);

      run_phase(7'd0,   0, 20);
      run_phase(7'd127, 1, 10);
      run_phase(7'd2,   2, 20);
      run_phase(7'd64,  3, 10);
      run_phase(7'd1,   1, 20);
      run_phase(7'd65,  2, 10);
      run_phase(LEN_W'($urandom_range(16, 1)), 3, 20);
      run_phase(LEN_W'($urandom_range(8, 3)),  0, 20);

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (flush_check.errors == 0 && flush_check.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
